// ===== hdl/char_lcd_nibble_command_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Character LCD nibble command generator: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_COMMAND_GENERATOR_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_COMMAND_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// condition must never hold
`define CLNCG_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
// antecedent implies consequent in the same cycle
`define CLNCG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CLNCG_ASSERT_NEVER(lbl, cond, msg)
`define CLNCG_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/clncg_pkg.sv =====
// ----------------------------------------------------------------------------
// clncg_pkg
// Types, command codes, controller byte constants and address helpers for
// the character LCD nibble command generator.
// ----------------------------------------------------------------------------
package clncg_pkg;

	// command codes
	localparam logic [3:0] CMD_INIT       = 4'd0;
	localparam logic [3:0] CMD_CLEAR      = 4'd1;
	localparam logic [3:0] CMD_TEXT       = 4'd2;
	localparam logic [3:0] CMD_RAW        = 4'd3;
	localparam logic [3:0] CMD_SET_CURSOR = 4'd4;
	localparam logic [3:0] CMD_DISP_ON    = 4'd5;
	localparam logic [3:0] CMD_DISP_OFF   = 4'd6;
	localparam logic [3:0] CMD_CURS_ON    = 4'd7;
	localparam logic [3:0] CMD_CURS_OFF   = 4'd8;
	localparam logic [3:0] CMD_BLINK_ON   = 4'd9;
	localparam logic [3:0] CMD_BLINK_OFF  = 4'd10;
	localparam logic [3:0] CMD_SCROLL_L   = 4'd11;
	localparam logic [3:0] CMD_SCROLL_R   = 4'd12;
	localparam logic [3:0] CMD_CGRAM      = 4'd13;
	localparam logic [3:0] CMD_CUSTOM     = 4'd14;

	// configuration register indexes
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	// configuration reset values
	localparam logic [5:0] COLUMNS_RST = 6'd16;
	localparam logic [2:0] ROWS_RST    = 3'd2;

	localparam int MAX_ROWS = 4;

	// special characters
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// controller bytes
	localparam logic [7:0] BYTE_WAKE      = 8'h33;
	localparam logic [7:0] BYTE_WAKE_4BIT = 8'h32;
	localparam logic [7:0] BYTE_FSET      = 8'h20;
	localparam logic [7:0] BYTE_FSET_2L   = 8'h08;
	localparam logic [7:0] BYTE_CTRL      = 8'h08;
	localparam logic [7:0] BYTE_CLEAR     = 8'h01;
	localparam logic [7:0] BYTE_ENTRY     = 8'h06;
	localparam logic [7:0] BYTE_SHIFT_L   = 8'h18;
	localparam logic [7:0] BYTE_SHIFT_R   = 8'h1C;
	localparam logic [7:0] BYTE_CGRAM     = 8'h40;
	localparam logic [7:0] BYTE_DDRAM     = 8'h80;

	// display flag bits
	localparam logic [2:0] FLAG_DISP  = 3'b100;
	localparam logic [2:0] FLAG_CURS  = 3'b010;
	localparam logic [2:0] FLAG_BLINK = 3'b001;

	// controller bytes per command at most
	localparam int LIST_DEPTH = 6;
	localparam int LIST_CW    = $clog2(LIST_DEPTH + 1);

	// byte queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [3:0] command;
		logic [7:0] value;
		logic [5:0] column;
		logic [1:0] row;
	} cmd_t;

	typedef struct packed {
		logic       register_select;
		logic [3:0] nibble;
		logic       last;
	} nib_t;

	// one controller byte in flight
	typedef struct packed {
		logic       rs;
		logic [7:0] data;
		logic       last;
	} ent_t;

	typedef struct packed {
		logic [5:0] columns;
		logic [2:0] rows;
	} cfg_t;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

	// rows beyond the display fold back to the top row
	function automatic logic [1:0] fix_row(input logic [2:0] r, input logic [2:0] rows);
		logic [1:0] o;
		o = (r >= rows || r >= 3'(MAX_ROWS)) ? 2'd0 : r[1:0];
		return o;
	endfunction

	function automatic logic [7:0] cursor_byte(input logic [5:0] col, input logic [1:0] r);
		logic [7:0] a;
		a = BYTE_DDRAM | ({2'b00, col} + row_base(r));
		return a;
	endfunction

endpackage

// ===== hdl/char_lcd_nibble_command_generator_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_generator_unit
// Character LCD command generator for a 4-bit bus: commands in, tagged
// nibbles out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_stall  | in_data  (cmd_t)
//  out     | output    | out_valid/out_stall| out_data (nib_t)
//  config  | input     | wr_en              | wr_index, wr_data
//
//  A command expands to up to six controller bytes; the front pushes one
//  byte a cycle into a four-entry queue while it has room, and the back
//  emits one nibble a cycle while the output is not stalled, two per byte,
//  paced by the single output register. Command 15 expands to no bytes.
//  The front takes the next command in the cycle its last byte is queued.
//  Reset clears cursor, flags, queue and output valid; configuration
//  returns to 16 columns and 2 rows.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_command_generator_unit_defines.svh"

module char_lcd_nibble_command_generator_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [5:0]       wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  clncg_pkg::cmd_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output clncg_pkg::nib_t  out_data
);

	clncg_pkg::cfg_t  cfg_q;
	logic             push;
	clncg_pkg::ent_t  push_data;
	logic             push_ready;
	logic             pop;
	logic             head_valid;
	clncg_pkg::ent_t  head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.columns <= clncg_pkg::COLUMNS_RST;
			cfg_q.rows    <= clncg_pkg::ROWS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				clncg_pkg::REG_COLUMNS: cfg_q.columns <= wr_data;
				clncg_pkg::REG_ROWS:    cfg_q.rows    <= wr_data[2:0];
				default:                cfg_q         <= cfg_q;
			endcase
		end
	end

	clncg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	clncg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	clncg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// queue never overflows and is never read empty; a stalled item holds
	`CLNCG_ASSERT_NEVER(a_no_overflow, push && !push_ready, "byte queue overflow")
	`CLNCG_ASSERT_IMPL(a_no_underflow, pop, head_valid, "byte queue read while empty")
	`CLNCG_ASSERT_IMPL(a_out_hold, $past(out_valid && out_stall), out_valid && (out_data == $past(out_data)), "stalled output item changed")

endmodule

// ===== hdl/clncg_front.sv =====
// ----------------------------------------------------------------------------
// clncg_front
// Accepts commands, tracks cursor and display flags, and expands each
// command into controller bytes pushed one a cycle while the queue has room.
// ----------------------------------------------------------------------------
module clncg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  clncg_pkg::cfg_t  cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  clncg_pkg::cmd_t  in_data,
	output logic             push,
	output clncg_pkg::ent_t  push_data,
	input  logic             push_ready
);

	clncg_pkg::ent_t                   list_q [clncg_pkg::LIST_DEPTH];
	logic [clncg_pkg::LIST_CW-1:0]     cnt_q;
	logic [5:0]                        col_q;
	logic [1:0]                        row_q;
	logic [2:0]                        flg_q;

	clncg_pkg::ent_t                   bl [clncg_pkg::LIST_DEPTH];
	logic [clncg_pkg::LIST_CW-1:0]     nb;
	logic [5:0]                        col_n;
	logic [1:0]                        row_n;
	logic [2:0]                        flg_n;
	logic                              accept;

	// push the head byte whenever the queue has room
	assign push      = (cnt_q != '0) && push_ready;
	assign push_data = '{rs: list_q[0].rs, data: list_q[0].data,
		last: (cnt_q == clncg_pkg::LIST_CW'(1))};
	assign in_stall  = !((cnt_q == '0) || ((cnt_q == clncg_pkg::LIST_CW'(1)) && push_ready));
	assign accept    = in_valid && !in_stall;

	// expand the command into controller bytes and next cursor state
	always_comb begin
		logic [5:0]      c1;
		logic [1:0]      r1;
		logic [1:0]      r2;
		logic            wrap;
		clncg_pkg::ent_t second;
		nb    = '0;
		col_n = col_q;
		row_n = row_q;
		flg_n = flg_q;
		c1    = col_q;
		r1    = row_q;
		r2    = '0;
		wrap  = 1'b0;
		second = '0;
		for (int i = 0; i < clncg_pkg::LIST_DEPTH; i++) begin
			bl[i] = '0;
		end
		unique case (in_data.command)
			clncg_pkg::CMD_INIT: begin
				col_n = '0;
				row_n = '0;
				flg_n = clncg_pkg::FLAG_DISP;
				bl[0] = '{rs: 1'b0, data: clncg_pkg::BYTE_WAKE, last: 1'b0};
				bl[1] = '{rs: 1'b0, data: clncg_pkg::BYTE_WAKE_4BIT, last: 1'b0};
				bl[2] = '{rs: 1'b0, data: (cfg.rows > 3'd1)
					? (clncg_pkg::BYTE_FSET | clncg_pkg::BYTE_FSET_2L)
					: clncg_pkg::BYTE_FSET, last: 1'b0};
				bl[3] = '{rs: 1'b0,
					data: clncg_pkg::BYTE_CTRL | {5'b0, clncg_pkg::FLAG_DISP}, last: 1'b0};
				bl[4] = '{rs: 1'b0, data: clncg_pkg::BYTE_CLEAR, last: 1'b0};
				bl[5] = '{rs: 1'b0, data: clncg_pkg::BYTE_ENTRY, last: 1'b0};
				nb = clncg_pkg::LIST_CW'(6);
			end
			clncg_pkg::CMD_CLEAR: begin
				bl[0] = '{rs: 1'b0, data: clncg_pkg::BYTE_CLEAR, last: 1'b0};
				nb = clncg_pkg::LIST_CW'(1);
			end
			clncg_pkg::CMD_TEXT: begin
				// wrap to the next row once past the last column
				if (col_q >= cfg.columns) begin
					wrap = 1'b1;
					c1 = '0;
					r1 = clncg_pkg::fix_row({1'b0, row_q} + 3'd1, cfg.rows);
				end
				if (in_data.value == clncg_pkg::CHAR_LF) begin
					r2 = clncg_pkg::fix_row({1'b0, r1} + 3'd1, cfg.rows);
					col_n = c1;
					row_n = r2;
					second = '{rs: 1'b0, data: clncg_pkg::cursor_byte(c1, r2), last: 1'b0};
				end else if (in_data.value == clncg_pkg::CHAR_CR) begin
					// fold a row left past the display by a smaller geometry
					r2 = clncg_pkg::fix_row({1'b0, r1}, cfg.rows);
					col_n = '0;
					row_n = r2;
					second = '{rs: 1'b0, data: clncg_pkg::cursor_byte(6'd0, r2), last: 1'b0};
				end else begin
					col_n = c1 + 6'd1;
					row_n = r1;
					second = '{rs: 1'b1, data: in_data.value, last: 1'b0};
				end
				if (wrap) begin
					bl[0] = '{rs: 1'b0, data: clncg_pkg::cursor_byte(6'd0, r1), last: 1'b0};
					bl[1] = second;
					nb = clncg_pkg::LIST_CW'(2);
				end else begin
					bl[0] = second;
					nb = clncg_pkg::LIST_CW'(1);
				end
			end
			clncg_pkg::CMD_RAW: begin
				bl[0] = '{rs: 1'b1, data: in_data.value, last: 1'b0};
				nb = clncg_pkg::LIST_CW'(1);
			end
			clncg_pkg::CMD_SET_CURSOR, clncg_pkg::CMD_CUSTOM: begin
				r2 = clncg_pkg::fix_row({1'b0, in_data.row}, cfg.rows);
				col_n = in_data.column;
				row_n = r2;
				bl[0] = '{rs: 1'b0, data: clncg_pkg::cursor_byte(in_data.column, r2),
					last: 1'b0};
				bl[1] = '{rs: 1'b1, data: in_data.value, last: 1'b0};
				nb = (in_data.command == clncg_pkg::CMD_CUSTOM)
					? clncg_pkg::LIST_CW'(2) : clncg_pkg::LIST_CW'(1);
			end
			clncg_pkg::CMD_DISP_ON, clncg_pkg::CMD_DISP_OFF, clncg_pkg::CMD_CURS_ON,
			clncg_pkg::CMD_CURS_OFF, clncg_pkg::CMD_BLINK_ON,
			clncg_pkg::CMD_BLINK_OFF: begin
				case (in_data.command)
					clncg_pkg::CMD_DISP_ON:  flg_n = flg_q | clncg_pkg::FLAG_DISP;
					clncg_pkg::CMD_DISP_OFF: flg_n = flg_q & ~clncg_pkg::FLAG_DISP;
					clncg_pkg::CMD_CURS_ON:  flg_n = flg_q | clncg_pkg::FLAG_CURS;
					clncg_pkg::CMD_CURS_OFF: flg_n = flg_q & ~clncg_pkg::FLAG_CURS;
					clncg_pkg::CMD_BLINK_ON: flg_n = flg_q | clncg_pkg::FLAG_BLINK;
					default:                 flg_n = flg_q & ~clncg_pkg::FLAG_BLINK;
				endcase
				bl[0] = '{rs: 1'b0, data: clncg_pkg::BYTE_CTRL | {5'b0, flg_n}, last: 1'b0};
				nb = clncg_pkg::LIST_CW'(1);
			end
			clncg_pkg::CMD_SCROLL_L: begin
				bl[0] = '{rs: 1'b0, data: clncg_pkg::BYTE_SHIFT_L, last: 1'b0};
				nb = clncg_pkg::LIST_CW'(1);
			end
			clncg_pkg::CMD_SCROLL_R: begin
				bl[0] = '{rs: 1'b0, data: clncg_pkg::BYTE_SHIFT_R, last: 1'b0};
				nb = clncg_pkg::LIST_CW'(1);
			end
			clncg_pkg::CMD_CGRAM: begin
				bl[0] = '{rs: 1'b0,
					data: clncg_pkg::BYTE_CGRAM | {2'b00, in_data.value[2:0], 3'b000},
					last: 1'b0};
				nb = clncg_pkg::LIST_CW'(1);
			end
			default: begin
				// unused code: drop silently
				nb = '0;
			end
		endcase
	end

	// hold cursor, flags and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			flg_q <= '0;
		end else if (accept) begin
			cnt_q <= nb;
			col_q <= col_n;
			row_q <= row_n;
			flg_q <= flg_n;
		end else if (push) begin
			cnt_q <= cnt_q - clncg_pkg::LIST_CW'(1);
		end
	end

	// load the byte list, advance it on each push
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < clncg_pkg::LIST_DEPTH; i++) begin
				list_q[i] <= bl[i];
			end
		end else if (push) begin
			for (int i = 0; i < clncg_pkg::LIST_DEPTH - 1; i++) begin
				list_q[i] <= list_q[i+1];
			end
		end
	end

endmodule

// ===== hdl/clncg_fifo.sv =====
// ----------------------------------------------------------------------------
// clncg_fifo
// Short byte queue between the command front and the nibble back.
// ----------------------------------------------------------------------------
module clncg_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clncg_pkg::ent_t  push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output clncg_pkg::ent_t  head
);

	clncg_pkg::ent_t                mem_q [clncg_pkg::FIFO_DEPTH];
	logic [clncg_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [clncg_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [clncg_pkg::FIFO_AW:0]    cnt_q;

	assign push_ready = (cnt_q != (clncg_pkg::FIFO_AW+1)'(clncg_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + clncg_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + clncg_pkg::FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (clncg_pkg::FIFO_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (clncg_pkg::FIFO_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/clncg_back.sv =====
// ----------------------------------------------------------------------------
// clncg_back
// Splits each queued byte into high then low nibble into the output register.
// ----------------------------------------------------------------------------
module clncg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  clncg_pkg::ent_t  head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output clncg_pkg::nib_t  out_data
);

	logic             out_v_q;
	clncg_pkg::nib_t  out_q;
	logic             phase_q;
	logic             load;

	assign load      = !out_v_q || !out_stall;
	assign pop       = load && head_valid && phase_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// output valid and nibble phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			out_v_q <= head_valid;
			if (head_valid) begin
				phase_q <= !phase_q;
			end
		end
	end

	// output payload: high nibble first, last only on the low nibble
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= '{register_select: head.rs,
				nibble: phase_q ? head.data[3:0] : head.data[7:4],
				last: phase_q && head.last};
		end
	end

endmodule

// ===== bench/tb_char_lcd_nibble_command_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_command_generator_unit
// Self-checking bench for the character LCD nibble command generator. A
// directed command list, then random command streams over several display
// geometries. Both channels idle and stall at random. Every output nibble is
// checked in order against a cycle-free model of the command expansion.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_command_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import clncg_pkg::*;

	// spare command code: the block ignores it
	localparam logic [3:0] CMD_NONE = 4'd15;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int GEOMETRIES     = 6;
	localparam int PHASE_ITEMS    = 25;
	localparam int MAX_NIBBLES    = 12;

	// one line of the directed list; typed rows carry at most one byte
	typedef struct {
		cmd_t       cmd;
		bit         typed;
		bit         one_byte;
		logic       rs;
		logic [7:0] data;
	} stim_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       wr_en     = 1'b0;
	logic       wr_index  = 1'b0;
	logic [5:0] wr_data   = 6'd0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	cmd_t       in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	nib_t       out_data;

	// model state and geometry
	logic [5:0] track_col   = 6'd0;
	logic [1:0] track_row   = 2'd0;
	logic [2:0] flag_bits   = 3'd0;
	logic [5:0] set_columns = COLUMNS_RST;
	logic [2:0] set_rows    = ROWS_RST;

	nib_t item_nibbles[$];
	nib_t lcd_nibble_queue[$];
	stim_row_t directed_rows[$];

	int  mismatch_count  = 0;
	int  nibbles_checked = 0;
	int  items_sent      = 0;
	int  idle_cycles     = 0;
	int  burst_left      = 0;
	bit  sender_quiet    = 1'b0;
	bit  receiver_quiet  = 1'b0;
	logic [15:0] stall_mask = 16'h0;
	logic [3:0]  stall_pos  = 4'd0;

	char_lcd_nibble_command_generator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// command expansion model
	// ------------------------------------------------------------------
	function automatic void queue_byte(input logic rs, input logic [7:0] b);
		nib_t n;
		n.register_select = rs;
		n.last = 1'b0;
		n.nibble = b[7:4];
		if (item_nibbles.size() < MAX_NIBBLES) item_nibbles.push_back(n);
		n.nibble = b[3:0];
		if (item_nibbles.size() < MAX_NIBBLES) item_nibbles.push_back(n);
	endfunction

	// fold rows past the display to the top row, then emit the DDRAM address
	function automatic void cursor_to(input logic [5:0] col, input logic [2:0] r);
		logic [1:0] rr;
		logic [7:0] base;
		rr = (r >= set_rows || r >= MAX_ROWS) ? 2'd0 : r[1:0];
		case (rr)
			2'd0:    base = 8'h00;
			2'd1:    base = 8'h40;
			2'd2:    base = 8'h14;
			default: base = 8'h54;
		endcase
		track_col = col;
		track_row = rr;
		queue_byte(1'b0, BYTE_DDRAM | ({2'b00, col} + base));
	endfunction

	function automatic void queue_control();
		queue_byte(1'b0, BYTE_CTRL | {5'b00000, flag_bits});
	endfunction

	function automatic void predict_lcd_nibbles(input cmd_t c);
		item_nibbles.delete();
		case (c.command)
			CMD_INIT: begin
				track_col = 6'd0;
				track_row = 2'd0;
				queue_byte(1'b0, BYTE_WAKE);
				queue_byte(1'b0, BYTE_WAKE_4BIT);
				queue_byte(1'b0, (set_rows > 3'd1) ? (BYTE_FSET | BYTE_FSET_2L) : BYTE_FSET);
				flag_bits = FLAG_DISP;
				queue_control();
				queue_byte(1'b0, BYTE_CLEAR);
				queue_byte(1'b0, BYTE_ENTRY);
			end
			CMD_CLEAR: queue_byte(1'b0, BYTE_CLEAR);
			CMD_TEXT: begin
				// wrap first, then act on the character
				if (track_col >= set_columns)
					cursor_to(6'd0, {1'b0, track_row} + 3'd1);
				if (c.value == CHAR_LF)
					cursor_to(track_col, {1'b0, track_row} + 3'd1);
				else if (c.value == CHAR_CR)
					cursor_to(6'd0, {1'b0, track_row});
				else begin
					queue_byte(1'b1, c.value);
					track_col = track_col + 6'd1;
				end
			end
			CMD_RAW:        queue_byte(1'b1, c.value);
			CMD_SET_CURSOR: cursor_to(c.column, {1'b0, c.row});
			CMD_DISP_ON: begin
				flag_bits = flag_bits | FLAG_DISP;
				queue_control();
			end
			CMD_DISP_OFF: begin
				flag_bits = flag_bits & ~FLAG_DISP;
				queue_control();
			end
			CMD_CURS_ON: begin
				flag_bits = flag_bits | FLAG_CURS;
				queue_control();
			end
			CMD_CURS_OFF: begin
				flag_bits = flag_bits & ~FLAG_CURS;
				queue_control();
			end
			CMD_BLINK_ON: begin
				flag_bits = flag_bits | FLAG_BLINK;
				queue_control();
			end
			CMD_BLINK_OFF: begin
				flag_bits = flag_bits & ~FLAG_BLINK;
				queue_control();
			end
			CMD_SCROLL_L: queue_byte(1'b0, BYTE_SHIFT_L);
			CMD_SCROLL_R: queue_byte(1'b0, BYTE_SHIFT_R);
			CMD_CGRAM:    queue_byte(1'b0, BYTE_CGRAM | {2'b00, c.value[2:0], 3'b000});
			CMD_CUSTOM: begin
				cursor_to(c.column, {1'b0, c.row});
				queue_byte(1'b1, c.value);
			end
			default: ;
		endcase
		if (item_nibbles.size() > 0)
			item_nibbles[item_nibbles.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic stim_row_t row_of(input logic [3:0] cmd, input logic [7:0] value,
			input logic [5:0] column, input logic [1:0] r, input bit typed,
			input bit one_byte, input logic rs, input logic [7:0] data);
		stim_row_t s;
		s.cmd.command = cmd;
		s.cmd.value   = value;
		s.cmd.column  = column;
		s.cmd.row     = r;
		s.typed       = typed;
		s.one_byte    = one_byte;
		s.rs          = rs;
		s.data        = data;
		return s;
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int pick;
		pick     = $urandom_range(0, 99);
		c.value  = 8'($urandom_range(0, 255));
		c.column = 6'($urandom_range(0, 63));
		c.row    = 2'($urandom_range(0, 3));
		if (pick < 30)
			c.command = CMD_TEXT;
		else if (pick < 36) begin
			c.command = CMD_TEXT;
			c.value   = CHAR_LF;
		end else if (pick < 41) begin
			c.command = CMD_TEXT;
			c.value   = CHAR_CR;
		end else if (pick < 50)
			c.command = CMD_SET_CURSOR;
		else if (pick < 54)
			c.command = CMD_INIT;
		else if (pick < 57)
			c.command = CMD_NONE;
		else
			c.command = 4'($urandom_range(0, 14));
		return c;
	endfunction

	// present one item in bursts, hold it until taken, then book its nibbles
	task automatic send_item(input stim_row_t s);
		int gap;
		if (!sender_quiet && burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s.cmd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_lcd_nibbles(s.cmd);
		if (s.typed) begin
			item_nibbles.delete();
			if (s.one_byte) begin
				queue_byte(s.rs, s.data);
				item_nibbles[1].last = 1'b1;
			end
		end
		foreach (item_nibbles[i]) lcd_nibble_queue.push_back(item_nibbles[i]);
		items_sent++;
		if (burst_left > 0) burst_left--;
		@(negedge clk);
	endtask

	// drop valid, wait for the last nibble, then let a silent command finish
	task automatic drain_block();
		in_valid <= 1'b0;
		while (lcd_nibble_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_geometry(input logic [5:0] cols, input logic [2:0] rws);
		wr_en    <= 1'b1;
		wr_index <= REG_COLUMNS;
		wr_data  <= cols;
		@(negedge clk);
		wr_index <= REG_ROWS;
		wr_data  <= {3'b000, rws};
		@(negedge clk);
		wr_en <= 1'b0;
		set_columns = cols;
		set_rows    = rws;
	endtask

	// ------------------------------------------------------------------
	// receiver: stall on a rotating mask, reloaded each time the position wraps
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		stall_pos <= stall_pos + 4'd1;
		if (stall_pos == 4'd15)
			stall_mask <= 16'($urandom & $urandom);
		out_stall <= !receiver_quiet && stall_mask[stall_pos];
	end

	// ------------------------------------------------------------------
	// check each taken nibble against the oldest booked one
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string what, input nib_t want, input nib_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: want rs=%0d nibble=%h last=%0d, got rs=%0d nibble=%h last=%0d",
				$realtime, what, want.register_select, want.nibble, want.last,
				got.register_select, got.nibble, got.last);
	endtask

	always @(posedge clk) begin
		nib_t want;
		if (arst_n && out_valid && !out_stall) begin
			nibbles_checked++;
			if (lcd_nibble_queue.size() == 0)
				note_mismatch("unexpected nibble", '0, out_data);
			else begin
				want = lcd_nibble_queue.pop_front();
				if (out_data.register_select !== want.register_select ||
						out_data.nibble !== want.nibble || out_data.last !== want.last)
					note_mismatch("nibble mismatch", want, out_data);
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: count cycles in which neither channel moves an item
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
		$display("char_lcd_nibble_command_generator_unit verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [5:0] cols;
		logic [2:0] rws;
		stim_row_t s;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed list at the reset geometry of 16 columns by 2 rows
		directed_rows.push_back(row_of(CMD_INIT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_CLEAR, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b0, 8'h01));
		directed_rows.push_back(row_of(CMD_RAW, 8'h00, 6'd0, 2'd0, 1'b1, 1'b1, 1'b1, 8'h00));
		directed_rows.push_back(row_of(CMD_RAW, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1, 8'hFF));
		directed_rows.push_back(row_of(CMD_TEXT, 8'h41, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_TEXT, CHAR_LF, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_TEXT, CHAR_CR, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_TEXT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_SET_CURSOR, 8'h00, 6'd39, 2'd3, 1'b0, 1'b0, 1'b0,
			8'h00));
		directed_rows.push_back(row_of(CMD_SET_CURSOR, 8'hFF, 6'd63, 2'd1, 1'b0, 1'b0, 1'b0,
			8'h00));
		directed_rows.push_back(row_of(CMD_TEXT, 8'h7A, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_DISP_OFF, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_CURS_ON, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_BLINK_ON, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_DISP_ON, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_CURS_OFF, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_BLINK_OFF, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0,
			8'h00));
		directed_rows.push_back(row_of(CMD_SCROLL_L, 8'h00, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0, 8'h18));
		directed_rows.push_back(row_of(CMD_SCROLL_R, 8'hFF, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0, 8'h1C));
		directed_rows.push_back(row_of(CMD_CGRAM, 8'hFF, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0, 8'h78));
		directed_rows.push_back(row_of(CMD_CGRAM, 8'h00, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0, 8'h40));
		directed_rows.push_back(row_of(CMD_CUSTOM, 8'h80, 6'd0, 2'd1, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_NONE, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_CUSTOM, 8'hFF, 6'd63, 2'd3, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(row_of(CMD_TEXT, CHAR_CR, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00));
		foreach (directed_rows[i]) send_item(directed_rows[i]);
		drain_block();

		// random streams, one geometry per phase, each opened by an init
		for (int g = 0; g < GEOMETRIES; g++) begin
			case (g)
				0: begin cols = 6'd0;  rws = 3'd0; end
				1: begin cols = 6'd1;  rws = 3'd1; end
				2: begin cols = 6'd40; rws = 3'd4; end
				3: begin cols = 6'd63; rws = 3'd7; end
				4: begin
					cols = 6'($urandom_range(1, 40));
					rws  = 3'($urandom_range(1, 4));
				end
				default: begin cols = COLUMNS_RST; rws = ROWS_RST; end
			endcase
			set_geometry(cols, rws);
			sender_quiet   = ($urandom_range(0, 3) == 0);
			receiver_quiet = ($urandom_range(0, 3) == 0);
			s = row_of(CMD_INIT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0, 8'h00);
			s.cmd.value = 8'($urandom_range(0, 255));
			send_item(s);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				s.cmd = random_command();
				send_item(s);
			end
			drain_block();
		end

		$display("%0d commands sent over %0d geometries after the reset one, %0d nibbles checked",
			items_sent, GEOMETRIES, nibbles_checked);
		$display("%0d mismatches, %0d nibbles still booked", mismatch_count,
			lcd_nibble_queue.size());
		if (mismatch_count == 0 && lcd_nibble_queue.size() == 0)
			$display("char_lcd_nibble_command_generator_unit verification clean");
		else
			$display("char_lcd_nibble_command_generator_unit verification failed");
		$finish;
	end

endmodule
